FILE: rtl/core/uudecode_stream_core_macros.svh
// assertion macros shared by the uudecode stream core
`ifndef UUDECODE_STREAM_CORE_MACROS_SVH
`define UUDECODE_STREAM_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/uud_pkg.sv
// shared types, constants and helper functions of the uudecode stream core
package uud_pkg;

    typedef enum logic [1:0] {
        PH_SEEK     = 2'd0,
        PH_SKIPLINE = 2'd1,
        PH_DATA     = 2'd2,
        PH_HALT     = 2'd3
    } phase_t;

    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_N      = 8'h6e;
    localparam logic [7:0] CHAR_D      = 8'h64;
    localparam logic [6:0] POS_MAX     = 7'd127;
    localparam logic [6:0] POS_LAST    = 7'd126;
    localparam logic [6:0] BEGIN_LEN   = 7'd6;
    localparam logic [5:0] FILL_SEXTET = 6'h20;
    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_END    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic step;    // apply the accepted input transfer
        logic flush;   // one fill position of a short line
    } uud_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register empty or being drained
        logic flush_start;  // current input ends a short data line
        logic flush_more;   // further fill positions follow this one
    } uud_status_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } take_t;

    // "begin " keyword character at a line position
    function automatic logic [7:0] begin_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h67;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6e;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    // (c - 0x20) & 0x3f
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        return {~c[5], c[4:0]};
    endfunction

    // combine the held sextet with a new one at line position pos (pos >= 1)
    function automatic take_t take_sextet(input logic [5:0] s, input logic [6:0] pos,
                                          input logic [5:0] held, input logic [5:0] emitted,
                                          input logic [5:0] count);
        take_t      t;
        logic [6:0] pm1;
        pm1    = pos - 7'd1;
        t.emit = (pm1[1:0] != 2'd0) && (emitted < count);
        case (pm1[1:0])
            2'd1:    t.data = {held, s[5:4]};
            2'd2:    t.data = {held[3:0], s[5:2]};
            2'd3:    t.data = {held[1:0], s};
            default: t.data = 8'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/core/uud_ctrl.sv
// controller state machine: accepts input transfers and sequences line-end flushes
module uud_ctrl
    import uud_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  uud_status_t status,
    output uud_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = status.out_free;
                cmd.step = s_tvalid && status.out_free;
                if (cmd.step && status.flush_start) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush = status.out_free;
                if (status.out_free && !status.flush_more) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/uud_datapath.sv
// datapath: parser state, sextet assembly and the output register
`include "uudecode_stream_core_macros.svh"

module uud_datapath
    import uud_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  uud_cmd_t    cmd,
    output uud_status_t status,
    input  logic [7:0]  char_code,
    input  logic        restart,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic        last_of_run
);

    phase_t     phase_reg, phase_next;
    logic [6:0] pos_reg, pos_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [5:0] emitted_reg, emitted_next;
    logic [5:0] held_reg, held_next;
    logic       match_reg, match_next;

    logic       valid_reg;
    logic       kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;

    // state as seen by the current input, after an optional restart
    phase_t     eff_phase;
    logic [6:0] eff_pos;
    logic [5:0] eff_cnt;
    logic [5:0] eff_emitted;
    logic [5:0] eff_held;
    logic       eff_match;
    logic       is_eol;
    logic [5:0] sext;
    take_t      tk_char;
    take_t      tk_fill;
    logic [5:0] fill_emitted;

    assign eff_phase   = restart ? PH_SEEK : phase_reg;
    assign eff_pos     = restart ? 7'd0 : pos_reg;
    assign eff_cnt     = restart ? 6'd0 : cnt_reg;
    assign eff_emitted = restart ? 6'd0 : emitted_reg;
    assign eff_held    = restart ? 6'd0 : held_reg;
    assign eff_match   = restart ? 1'b1 : match_reg;

    assign is_eol = (char_code == CHAR_CR) || (char_code == CHAR_LF);
    assign sext   = sextet_of(char_code);

    assign tk_char = take_sextet(sext, eff_pos, eff_held, eff_emitted, eff_cnt);
    assign tk_fill = take_sextet(FILL_SEXTET, pos_reg, held_reg, emitted_reg, cnt_reg);
    assign fill_emitted = emitted_reg + {5'd0, tk_fill.emit};

    assign status.out_free    = !valid_reg || m_tready;
    assign status.flush_start = is_eol && (eff_pos != 7'd0) && (eff_phase == PH_DATA)
                                && (eff_emitted < eff_cnt) && (eff_pos < POS_MAX);
    assign status.flush_more  = (fill_emitted < cnt_reg) && (pos_reg < POS_LAST);

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        held_next    = held_reg;
        match_next   = match_reg;
        load         = 1'b0;
        kind_next    = KIND_DATA;
        byte_next    = 8'd0;
        last_next    = 1'b1;

        if (cmd.step) begin
            phase_next   = eff_phase;
            pos_next     = eff_pos;
            cnt_next     = eff_cnt;
            emitted_next = eff_emitted;
            held_next    = eff_held;
            match_next   = eff_match;
            if (eff_phase != PH_HALT) begin
                if (is_eol) begin
                    if ((eff_pos != 7'd0) && !status.flush_start) begin
                        if (eff_phase == PH_SKIPLINE) begin
                            phase_next = PH_DATA;
                        end
                        pos_next     = 7'd0;
                        cnt_next     = 6'd0;
                        emitted_next = 6'd0;
                        held_next    = 6'd0;
                        match_next   = 1'b1;
                    end
                end else if (eff_pos < POS_MAX) begin
                    pos_next = eff_pos + 7'd1;
                    if (eff_phase == PH_SEEK) begin
                        if (eff_pos < BEGIN_LEN) begin
                            match_next = eff_match && (char_code == begin_char(eff_pos[2:0]));
                            if (match_next && (eff_pos == BEGIN_LEN - 7'd1)) begin
                                phase_next = PH_SKIPLINE;
                            end
                        end
                    end else if (eff_phase == PH_DATA) begin
                        if (eff_pos == 7'd0) begin
                            match_next   = (char_code == CHAR_E);
                            cnt_next     = sext;
                            emitted_next = 6'd0;
                            if (sext == 6'd0) begin
                                load = 1'b1;
                                kind_next = KIND_END;
                            end
                        end else if ((eff_pos == 7'd2) && eff_match && (char_code == CHAR_D)) begin
                            load      = 1'b1;
                            kind_next = KIND_END;
                        end else begin
                            if ((eff_pos == 7'd1) && (char_code != CHAR_N)) begin
                                match_next = 1'b0;
                            end
                            if (eff_pos == 7'd2) begin
                                match_next = 1'b0;
                            end
                            held_next = sext;
                            if (tk_char.emit) begin
                                load         = 1'b1;
                                byte_next    = tk_char.data;
                                emitted_next = eff_emitted + 6'd1;
                            end
                        end
                        // end marker halts and clears the line
                        if (load && (kind_next == KIND_END)) begin
                            phase_next   = PH_HALT;
                            pos_next     = 7'd0;
                            cnt_next     = 6'd0;
                            emitted_next = 6'd0;
                            held_next    = 6'd0;
                            match_next   = 1'b1;
                        end
                    end
                end
            end
        end else if (cmd.flush) begin
            held_next    = FILL_SEXTET;
            pos_next     = pos_reg + 7'd1;
            emitted_next = fill_emitted;
            if (tk_fill.emit) begin
                load      = 1'b1;
                byte_next = tk_fill.data;
                last_next = !status.flush_more;
            end
            if (!status.flush_more) begin
                pos_next     = 7'd0;
                cnt_next     = 6'd0;
                emitted_next = 6'd0;
                held_next    = 6'd0;
                match_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEEK;
            pos_reg     <= 7'd0;
            cnt_reg     <= 6'd0;
            emitted_reg <= 6'd0;
            held_reg    <= 6'd0;
            match_reg   <= 1'b1;
            valid_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            held_reg    <= held_next;
            match_reg   <= match_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid    = valid_reg;
    assign result_kind = kind_reg;
    assign data_byte   = byte_reg;
    assign last_of_run = last_reg;

    `UUD_ASSERT_NOW(a_end_byte_zero, valid_reg && (kind_reg == KIND_END), byte_reg == 8'd0, "end marker carries a nonzero byte")
    `UUD_ASSERT_NOW(a_emitted_bounded, 1'b1, emitted_reg <= cnt_reg, "more bytes emitted than the line count")
    `UUD_ASSERT_NOW(a_halt_clear, phase_reg == PH_HALT, pos_reg == 7'd0, "halted with line state left")
    `UUD_ASSERT_NEXT(a_end_halts, load && (kind_next == KIND_END), phase_reg == PH_HALT, "end marker without halt")

endmodule

FILE: rtl/core/uudecode_stream_core.sv
// top level of the streaming uudecode core
//
// input channel s_*: one text byte per transfer in s_tdata, s_tuser high restarts the
// parser (back to seeking the begin line) before that byte is handled.
// output channel m_*: one decoded byte per transfer in m_tdata with m_tuser low, or the
// end-of-data marker with m_tuser high and m_tdata zero; m_tlast marks the final result
// caused by one input transfer.
// results: a result is registered and appears on m_* in the cycle after the input transfer
// that causes it; flush results of a short line come out of the flush state after it.
// throughput: one input transfer per cycle while the output side keeps up and no flush
// runs; the single output register frees in the cycle it is taken, so a new byte is
// taken alongside. a line end on a short data line starts a flush that steps one fill
// position a cycle while the output register is free, through a separate fill sextet
// unit, and holds s_tready low meanwhile.
// after the end marker every byte is swallowed until a transfer with restart set.
// reset: synchronous active-low aresetn clears the parser to seeking the begin line and
// empties the output register.
// stall: with m_tready low a pending result holds and s_tready drops until it is taken.
module uudecode_stream_core
    import uud_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // [0] restart
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tuser,   // [0] result_kind
    output logic       m_tlast
);

    uud_cmd_t    cmd;     // controller commands
    uud_status_t status;  // datapath status

    // sequencing of accepts and flush steps
    uud_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // parser state, decoding and output register
    uud_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .char_code   (s_tdata),
        .restart     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result_kind (m_tuser),
        .data_byte   (m_tdata),
        .last_of_run (m_tlast)
    );

endmodule

FILE: dv/tb_uudecode_stream_core.sv
// testbench for the streaming uudecode core: decode scoreboard plus directed and random text
class decoded_stream_board;
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } decoded_t;

    decoded_t        owed_results[$];
    uud_pkg::phase_t phase;
    logic [6:0]      line_pos;
    logic [5:0]      line_count;
    logic [5:0]      line_emitted;
    logic [5:0]      held;
    logic            still_matches;
    int              mismatches;

    function new();
        mismatches = 0;
        restart_parser();
    endfunction

    function void clear_line();
        line_pos      = 7'd0;
        line_count    = 6'd0;
        line_emitted  = 6'd0;
        held          = 6'd0;
        still_matches = 1'b1;
    endfunction

    function void restart_parser();
        phase = uud_pkg::PH_SEEK;
        clear_line();
    endfunction

    function logic [5:0] sextet_value(logic [7:0] c);
        return 6'((c - 8'h20) & 8'h3f);
    endfunction

    function void owe(logic kind, logic [7:0] data);
        decoded_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        owed_results.push_back(r);
    endfunction

    // four sextets give three bytes, a byte is out once its bits are all in
    function void fold_sextet(logic [5:0] s, logic [6:0] pos);
        logic [1:0] slot;
        int         h;
        int         v;
        slot = 2'(pos - 7'd1);
        h    = int'(held);
        v    = int'(s);
        if (slot != 2'd0 && line_emitted < line_count) begin
            case (slot)
                2'd1:    owe(uud_pkg::KIND_DATA, 8'((h << 2) | (v >> 4)));
                2'd2:    owe(uud_pkg::KIND_DATA, 8'((h << 4) | (v >> 2)));
                default: owe(uud_pkg::KIND_DATA, 8'((h << 6) | v));
            endcase
            line_emitted = line_emitted + 6'd1;
        end
        held = s;
    endfunction

    function void halt_parser();
        owe(uud_pkg::KIND_END, 8'd0);
        phase = uud_pkg::PH_HALT;
        clear_line();
    endfunction

    // predicts the results of one input transfer, returns 0 when the byte is swallowed
    function bit take_char(logic [7:0] c, logic rst);
        int         first;
        logic [6:0] p;
        logic [6:0] pos;
        string      kw;
        kw    = "begin ";
        first = owed_results.size();
        if (rst)
            restart_parser();
        if (phase == uud_pkg::PH_HALT)
            return 1'b0;
        if (c == uud_pkg::CHAR_CR || c == uud_pkg::CHAR_LF) begin
            if (line_pos != 7'd0) begin
                if (phase == uud_pkg::PH_DATA) begin
                    // short line: owed bytes come out with fill sextets
                    pos = line_pos;
                    while (line_emitted < line_count && pos < uud_pkg::POS_MAX) begin
                        fold_sextet(uud_pkg::FILL_SEXTET, pos);
                        pos = pos + 7'd1;
                    end
                end else if (phase == uud_pkg::PH_SKIPLINE) begin
                    phase = uud_pkg::PH_DATA;
                end
                clear_line();
            end
        end else begin
            p = line_pos;
            if (p < uud_pkg::POS_MAX) begin
                line_pos = p + 7'd1;
                if (phase == uud_pkg::PH_SEEK) begin
                    if (p < 7'd6) begin
                        still_matches = still_matches && (c == kw[int'(p)]);
                        if (still_matches && p == 7'd5)
                            phase = uud_pkg::PH_SKIPLINE;
                    end
                end else if (phase == uud_pkg::PH_DATA) begin
                    if (p == 7'd0) begin
                        still_matches = (c == uud_pkg::CHAR_E);
                        line_count    = sextet_value(c);
                        line_emitted  = 6'd0;
                        if (line_count == 6'd0)
                            halt_parser();
                    end else if (p == 7'd1) begin
                        if (c != uud_pkg::CHAR_N)
                            still_matches = 1'b0;
                        fold_sextet(sextet_value(c), p);
                    end else if (p == 7'd2 && still_matches && c == uud_pkg::CHAR_D) begin
                        halt_parser();
                    end else begin
                        if (p == 7'd2)
                            still_matches = 1'b0;
                        fold_sextet(sextet_value(c), p);
                    end
                end
            end
        end
        if (owed_results.size() > first)
            owed_results[owed_results.size() - 1].last = 1'b1;
        return 1'b1;
    endfunction

    function void match_result(logic kind, logic [7:0] data, logic last);
        decoded_t want;
        if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d data %02h last %0d", kind, data, last);
            return;
        end
        want = owed_results.pop_front();
        if (want.kind !== kind || want.data !== data || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected kind %0d data %02h last %0d, got %0d %02h %0d",
                         want.kind, want.data, want.last, kind, data, last);
        end
    endfunction

    function int pending();
        return owed_results.size();
    endfunction
endclass

module tb_uudecode_stream_core;
    timeunit 1ns;
    timeprecision 1ps;
    import uud_pkg::*;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    decoded_stream_board board;
    int                  burst_left;
    int                  active_items;
    bit                  restart_due;
    bit                  hold_req;

    uudecode_stream_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] char_code
        .s_tuser  (s_tuser),   // [0] restart
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] data_byte
        .m_tuser  (m_tuser),   // [0] result_kind
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // one byte transfer; the sender runs in bursts with random gaps in between
    task automatic put_char(input logic [7:0] c, input logic rst);
        int   gap;
        logic r;
        r           = rst | restart_due;
        restart_due = 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= r;
        do @(posedge aclk); while (!s_tready);
        if (board.take_char(c, r))
            active_items++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            put_char(t[i], 1'b0);
    endtask

    task automatic send_eol();
        case ($urandom_range(0, 5))
            0, 1: put_char(CHAR_LF, 1'b0);
            2:    put_char(CHAR_CR, 1'b0);
            3, 4: begin
                put_char(CHAR_CR, 1'b0);
                put_char(CHAR_LF, 1'b0);
            end
            default: begin
                put_char(CHAR_LF, 1'b0);
                put_char(CHAR_LF, 1'b0);
            end
        endcase
    endtask

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_CR || c == CHAR_LF)
            c = 8'h7e;
        return c;
    endfunction

    // any of the four characters that carry sextet s, never a line end
    function automatic logic [7:0] enc_sextet(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s} + 8'h20;
        case ($urandom_range(0, 7))
            0:       c = c + 8'h40;
            1:       c = c + 8'h80;
            2:       c = c + 8'hc0;
            default: ;
        endcase
        if (c == CHAR_CR || c == CHAR_LF)
            c = {2'b00, s} + 8'h20;
        return c;
    endfunction

    // junk, begin line, a few data lines (some short or long), end line, ignored tail
    task automatic send_file(input bit force_long);
        int    pick;
        int    cnt;
        int    full;
        int    len;
        int    n_lines;
        string hdr;
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: send_text("begin");
                1: send_text("beginx 644 q");
                2: send_text("Begin 644 q");
                default: repeat ($urandom_range(1, 10)) put_char(rand_text_char(), 1'b0);
            endcase
            send_eol();
        end
        if ($urandom_range(0, 1) == 0)
            hdr = "begin 644 data.bin";
        else
            hdr = "begin 600 x";
        send_text(hdr);
        send_eol();
        n_lines = $urandom_range(1, 4);
        for (int i = 0; i < n_lines; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                cnt = $urandom_range(1, 15);
            else if (pick < 19)
                cnt = $urandom_range(16, 45);
            else
                cnt = $urandom_range(46, 63);
            full = ((cnt + 2) / 3) * 4;
            pick = $urandom_range(0, 9);
            if (force_long && i == 0)
                len = $urandom_range(127, 134);
            else if (pick < 2)
                len = $urandom_range(0, full - 1);
            else if (pick == 2)
                len = full + $urandom_range(1, 6);
            else
                len = full;
            put_char(enc_sextet(6'(cnt)), 1'b0);
            repeat (len) put_char(enc_sextet(6'($urandom_range(0, 63))), 1'b0);
            send_eol();
        end
        case ($urandom_range(0, 3))
            0, 1: send_text("end");
            2:    put_char(8'h60, 1'b0);
            default: send_text(" ");
        endcase
        send_eol();
        // swallowed while halted
        repeat ($urandom_range(0, 3)) put_char(rand_text_char(), 1'b0);
        restart_due = 1'b1;
    endtask

    task automatic send_noise();
        logic [7:0] c;
        repeat ($urandom_range(5, 20)) begin
            if ($urandom_range(0, 4) == 0)
                c = ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF;
            else
                c = 8'($urandom_range(0, 255));
            put_char(c, $urandom_range(0, 7) == 0);
        end
        restart_due = 1'b1;
    endtask

    // result side: sample at the rising edge, change ready at the falling edge
    initial begin : drain_side
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.match_result(m_tuser, m_tdata, m_tlast);
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                // long hold-off so the block backs up into its input
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= mode_left[0];
                endcase
            end
        end
    end

    initial begin : stimulus
        int file_idx;
        board        = new();
        burst_left   = 0;
        active_items = 0;
        restart_due  = 1'b0;
        hold_req     = 1'b0;
        file_idx     = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: short begin line, begin line, empty line, extreme characters
        send_text("begin");
        put_char(CHAR_LF, 1'b0);
        send_text("begin ");
        put_char(CHAR_CR, 1'b0);
        put_char(CHAR_LF, 1'b0);
        put_char(8'h23, 1'b0);
        put_char(8'h00, 1'b0);
        put_char(8'hff, 1'b0);
        put_char(8'h7f, 1'b0);
        put_char(8'h80, 1'b0);
        put_char(CHAR_LF, 1'b0);
        // short data line with a big flush, then a line that only looks like end
        send_text("Nz");
        put_char(CHAR_CR, 1'b0);
        send_text("en");
        put_char(CHAR_LF, 1'b0);
        // end line, then a byte swallowed while halted
        send_text("end");
        put_char(8'h71, 1'b0);
        restart_due = 1'b1;

        // random: mostly well-formed files, some noise
        hold_req = 1'b1;
        while (active_items < 260) begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_file(file_idx == 1);
            file_idx++;
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
